// File: design/afd_pkg.sv
`timescale 1ns / 1ps

package afd_pkg;

  // default sizes handed to the top level
  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed field widths
  localparam int MAG_W     = 32;
  localparam int LIMIT_W   = 32;
  localparam int WINDOW_W  = 16;
  localparam int COOL_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // reset values, raw Q8 units squared (1 g = 9.81 * 256)
  localparam logic [MAG_W-1:0]    ONE_G_SQ            = 32'd6306929;
  localparam logic [LIMIT_W-1:0]  DEF_FREEFALL_LIMIT  = 32'd1009109;
  localparam logic [LIMIT_W-1:0]  DEF_IMPACT_LIMIT    = 32'd39418307;
  localparam logic [WINDOW_W-1:0] DEF_IMPACT_WINDOW   = 16'd500;
  localparam logic [WINDOW_W-1:0] DEF_FREEFALL_TIMEOUT = 16'd1000;
  localparam logic [COOL_W-1:0]   DEF_ALERT_COOLDOWN  = 32'd60000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREEFALL_LIMIT   = 3'd0,
    REG_IMPACT_LIMIT     = 3'd1,
    REG_IMPACT_WINDOW    = 3'd2,
    REG_FREEFALL_TIMEOUT = 3'd3,
    REG_ALERT_COOLDOWN   = 3'd4
  } afd_reg_e;

  // status flags of one result, packed into tuser from bit 0 up
  typedef struct packed {
    logic free_fall_active;
    logic alert_raised;
    logic fall_detected;
  } afd_flags_t;

endpackage

// File: design/afd_magnitude.sv
`timescale 1ns / 1ps

module afd_magnitude
  import afd_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic [SAMPLE_BITS-1:0] accel_x,
  input  logic [SAMPLE_BITS-1:0] accel_y,
  input  logic [SAMPLE_BITS-1:0] accel_z,
  output logic [MAG_W-1:0]       magnitude_sq
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] abs_x;
  logic [SAMPLE_BITS-1:0] abs_y;
  logic [SAMPLE_BITS-1:0] abs_z;
  logic [SQ_W-1:0]        sq_x;
  logic [SQ_W-1:0]        sq_y;
  logic [SQ_W-1:0]        sq_z;
  logic [SQ_W-1:0]        sq_sum;

  // absolute values; the most negative code reads as 2^(n-1) unsigned
  assign abs_x = accel_x[SAMPLE_BITS-1] ? (~accel_x + 1'b1) : accel_x;
  assign abs_y = accel_y[SAMPLE_BITS-1] ? (~accel_y + 1'b1) : accel_y;
  assign abs_z = accel_z[SAMPLE_BITS-1] ? (~accel_z + 1'b1) : accel_z;

  // three squares in parallel
  assign sq_x = SQ_W'(abs_x) * SQ_W'(abs_x);
  assign sq_y = SQ_W'(abs_y) * SQ_W'(abs_y);
  assign sq_z = SQ_W'(abs_z) * SQ_W'(abs_z);

  // sum is at most 3 * 2^(2n-2), so it fits 2n bits
  assign sq_sum = sq_x + sq_y + sq_z;

  assign magnitude_sq = MAG_W'(sq_sum);

endmodule

// File: design/accel_fall_detector.sv
`timescale 1ns / 1ps

// Free-fall / impact fall detector. Each input transfer is one tick: a
// millisecond timestamp plus, when tuser is set, a new accelerometer sample.
// The block accepts a tick in every cycle while the output side takes
// results. The sample squares are formed into an input register, and the
// detector state (held magnitude, free-fall window, last alert time) is
// read and updated as the result register is loaded, so a tick always
// sees the state left by the one before it. All time differences wrap
// modulo 2^TIME_BITS. Configuration writes are taken in any cycle and
// should only be made while idle.
module accel_fall_detector
  import afd_pkg::*;
#(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,

  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // accel_x, accel_y, accel_z, time_ms, zero padding
  input  logic [((3*SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // sample_valid
  input  logic                 s_axis_tuser,

  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // magnitude_sq
  output logic [MAG_W-1:0]     m_axis_tdata,
  // fall_detected, alert_raised, free_fall_active
  output logic [2:0]           m_axis_tuser,

  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CMP_W = (TIME_BITS > COOL_W) ? TIME_BITS : COOL_W;

  // configuration registers
  logic [LIMIT_W-1:0]  freefall_limit_sq;
  logic [LIMIT_W-1:0]  impact_limit_sq;
  logic [WINDOW_W-1:0] impact_window_ms;
  logic [WINDOW_W-1:0] freefall_timeout_ms;
  logic [COOL_W-1:0]   alert_cooldown_ms;

  // input register
  logic                 s1_valid;
  logic                 s1_sample_valid;
  logic [MAG_W-1:0]     s1_mag;
  logic [TIME_BITS-1:0] s1_time;

  // detector state
  logic                 in_free_fall;
  logic [TIME_BITS-1:0] free_fall_start;
  logic [MAG_W-1:0]     held_magnitude_sq;
  logic [TIME_BITS-1:0] last_alert_time;

  // result register
  logic                 out_valid;
  logic [MAG_W-1:0]     out_mag;
  afd_flags_t           out_flags;

  logic [SAMPLE_BITS-1:0] in_x;
  logic [SAMPLE_BITS-1:0] in_y;
  logic [SAMPLE_BITS-1:0] in_z;
  logic [TIME_BITS-1:0]   in_time;
  logic [MAG_W-1:0]       in_mag;

  logic                 out_free;
  logic                 advance;
  logic                 in_fire;

  logic [MAG_W-1:0]     mag;
  logic                 arm;
  logic                 active;
  logic [TIME_BITS-1:0] start_next;
  logic [TIME_BITS-1:0] dt;
  logic [TIME_BITS-1:0] dt_alert;
  logic                 impact;
  logic                 timeout;
  logic                 cooldown_passed;
  logic                 in_free_fall_next;
  afd_flags_t           flags_next;

  // unpack the input transfer
  assign in_x    = s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign in_y    = s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign in_z    = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign in_time = s_axis_tdata[3*SAMPLE_BITS +: TIME_BITS];

  afd_magnitude #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_magnitude (
    .accel_x      (in_x),
    .accel_y      (in_y),
    .accel_z      (in_z),
    .magnitude_sq (in_mag)
  );

  // pipeline flow control
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_limit_sq   <= DEF_FREEFALL_LIMIT;
      impact_limit_sq     <= DEF_IMPACT_LIMIT;
      impact_window_ms    <= DEF_IMPACT_WINDOW;
      freefall_timeout_ms <= DEF_FREEFALL_TIMEOUT;
      alert_cooldown_ms   <= DEF_ALERT_COOLDOWN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREEFALL_LIMIT:   freefall_limit_sq   <= cfg_data[LIMIT_W-1:0];
        REG_IMPACT_LIMIT:     impact_limit_sq     <= cfg_data[LIMIT_W-1:0];
        REG_IMPACT_WINDOW:    impact_window_ms    <= cfg_data[WINDOW_W-1:0];
        REG_FREEFALL_TIMEOUT: freefall_timeout_ms <= cfg_data[WINDOW_W-1:0];
        REG_ALERT_COOLDOWN:   alert_cooldown_ms   <= cfg_data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_valid <= s_axis_tuser;
      s1_mag          <= in_mag;
      s1_time         <= in_time;
    end
  end

  // detector step on the registered tick
  always_comb begin
    mag        = s1_sample_valid ? s1_mag : held_magnitude_sq;
    arm        = !in_free_fall && (mag < freefall_limit_sq);
    active     = in_free_fall || arm;
    start_next = arm ? s1_time : free_fall_start;
    dt         = s1_time - start_next;
    dt_alert   = s1_time - last_alert_time;
    impact     = active && (mag > impact_limit_sq);
    timeout    = active && (dt > TIME_BITS'(freefall_timeout_ms));
    cooldown_passed = CMP_W'(dt_alert) > CMP_W'(alert_cooldown_ms);

    in_free_fall_next           = active && !impact && !timeout;
    flags_next.fall_detected    = impact && (dt < TIME_BITS'(impact_window_ms));
    flags_next.alert_raised     = flags_next.fall_detected && cooldown_passed;
    flags_next.free_fall_active = in_free_fall_next;
  end

  // detector state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_free_fall      <= 1'b0;
      free_fall_start   <= '0;
      held_magnitude_sq <= ONE_G_SQ;
      last_alert_time   <= '0;
    end else if (advance) begin
      in_free_fall      <= in_free_fall_next;
      free_fall_start   <= start_next;
      held_magnitude_sq <= mag;
      if (flags_next.alert_raised) begin
        last_alert_time <= s1_time;
      end
    end
  end

  // result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_mag   <= mag;
      out_flags <= flags_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_mag;
  assign m_axis_tuser  = {out_flags.free_fall_active, out_flags.alert_raised,
                          out_flags.fall_detected};

endmodule

// File: tb/tb_accel_fall_detector.sv
`timescale 1ns / 1ps

module tb_accel_fall_detector;
  import afd_pkg::*;

  localparam int TDATA_W         = ((3*DEF_SAMPLE_BITS+DEF_TIME_BITS+7)/8)*8;
  localparam int SMP_W           = DEF_SAMPLE_BITS;
  localparam int TIME_W          = DEF_TIME_BITS;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 6;
  localparam logic [LIMIT_W-1:0] MAX_MAG_SQ = 32'd3221225472;
  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one tick as offered on the input stream
  typedef struct {
    logic                    has_sample;
    logic signed [SMP_W-1:0] ax;
    logic signed [SMP_W-1:0] ay;
    logic signed [SMP_W-1:0] az;
    logic [TIME_W-1:0]       stamp_ms;
  } tick_t;

  // one detector outcome as seen on the result stream
  typedef struct packed {
    afd_flags_t       flags;
    logic [MAG_W-1:0] mag;
  } outcome_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    tick_t                tick;
    logic                 typed;
    outcome_t             want;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } step_row_t;

  typedef enum {MOTION_REST, MOTION_DROP, MOTION_HIT, MOTION_NOISE} motion_e;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [MAG_W-1:0]     m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  accel_fall_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // mirror of the detector registers and state
  logic [LIMIT_W-1:0]  ff_limit;
  logic [LIMIT_W-1:0]  impact_limit;
  logic [WINDOW_W-1:0] impact_window;
  logic [WINDOW_W-1:0] ff_timeout;
  logic [COOL_W-1:0]   cooldown;
  logic                armed;
  logic [TIME_W-1:0]   window_start;
  logic [MAG_W-1:0]    held_mag;
  logic [TIME_W-1:0]   last_alert;

  outcome_t    pending_outcomes[$];
  step_row_t   directed_rows[$];
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          tx_idle_pct = 18;
  int          rx_idle_pct = 46;
  bit          stall_request = 1'b0;
  logic [TIME_W-1:0] wall_ms;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time,
             pending_outcomes.size());
    $display("tb_accel_fall_detector: FAIL");
    $finish;
  end

  // square of one raw axis value, magnitude taken first
  function automatic logic [MAG_W-1:0] axis_sq(logic signed [SMP_W-1:0] v);
    logic [SMP_W:0] a;
    a = v[SMP_W-1] ? ({1'b1, {SMP_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
    return MAG_W'(a) * MAG_W'(a);
  endfunction

  // next detector outcome for one tick, advancing the mirrored state
  function automatic outcome_t detector_outcome(tick_t t);
    outcome_t          o;
    logic [TIME_W-1:0] dt;
    o = '0;
    if (t.has_sample)
      held_mag = axis_sq(t.ax) + axis_sq(t.ay) + axis_sq(t.az);
    if (!armed && held_mag < ff_limit) begin
      armed = 1'b1;
      window_start = t.stamp_ms;
    end
    if (armed) begin
      dt = t.stamp_ms - window_start;
      if (held_mag > impact_limit) begin
        if (dt < TIME_W'(impact_window))
          o.flags.fall_detected = 1'b1;
        armed = 1'b0;
      end
      if (dt > TIME_W'(ff_timeout))
        armed = 1'b0;
    end
    dt = t.stamp_ms - last_alert;
    if (o.flags.fall_detected && dt > cooldown) begin
      o.flags.alert_raised = 1'b1;
      last_alert = t.stamp_ms;
    end
    o.flags.free_fall_active = armed;
    o.mag = held_mag;
    return o;
  endfunction

  function automatic logic signed [SMP_W-1:0] sym(int unsigned span);
    return SMP_W'(int'($urandom_range(2*span)) - int'(span));
  endfunction

  function automatic step_row_t tk(logic sv, logic signed [SMP_W-1:0] ax,
                                   logic signed [SMP_W-1:0] ay,
                                   logic signed [SMP_W-1:0] az,
                                   logic [TIME_W-1:0] stamp);
    step_row_t r;
    r = '{kind: ROW_TICK, typed: 1'b0, want: '0, idx: '0, data: '0,
          tick: '{has_sample: sv, ax: ax, ay: ay, az: az, stamp_ms: stamp}};
    return r;
  endfunction

  function automatic step_row_t tk_exp(logic sv, logic signed [SMP_W-1:0] ax,
                                       logic signed [SMP_W-1:0] ay,
                                       logic signed [SMP_W-1:0] az,
                                       logic [TIME_W-1:0] stamp,
                                       logic [MAG_W-1:0] mag, logic fall,
                                       logic alert, logic ffa);
    step_row_t r;
    r = tk(sv, ax, ay, az, stamp);
    r.typed = 1'b1;
    r.want.mag = mag;
    r.want.flags.fall_detected = fall;
    r.want.flags.alert_raised = alert;
    r.want.flags.free_fall_active = ffa;
    return r;
  endfunction

  function automatic step_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    step_row_t r;
    r = tk(1'b0, '0, '0, '0, '0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // offer one tick and log what it should produce once transferred
  task automatic send_tick(tick_t t, logic typed, outcome_t want);
    outcome_t o;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= t.has_sample;
    s_axis_tdata  <= {t.stamp_ms, t.az, t.ay, t.ax};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    o = detector_outcome(t);
    pending_outcomes.push_back(typed ? want : o);
    ticks_sent++;
  endtask

  task automatic wait_outcomes_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FREEFALL_LIMIT:   ff_limit      = data;
      REG_IMPACT_LIMIT:     impact_limit  = data;
      REG_IMPACT_WINDOW:    impact_window = data[WINDOW_W-1:0];
      REG_FREEFALL_TIMEOUT: ff_timeout    = data[WINDOW_W-1:0];
      REG_ALERT_COOLDOWN:   cooldown      = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one tick of a given kind of motion, time moving on from the last one except for noise, which jumps to a random time
  task automatic random_step(motion_e m);
    tick_t t;
    if ($urandom_range(19) == 0)
      wall_ms += $urandom;
    else
      wall_ms += $urandom_range(0, 180);
    t.has_sample = ($urandom_range(7) != 0);
    t.stamp_ms = wall_ms;
    case (m)
      MOTION_REST: begin
        t.ax = sym(300);
        t.ay = sym(300);
        t.az = sym(400) + ($urandom_range(1) ? 16'sd2511 : -16'sd2511);
      end
      MOTION_DROP: begin
        t.ax = sym(700);
        t.ay = sym(700);
        t.az = sym(700);
      end
      MOTION_HIT: begin
        t.ax = SMP_W'($urandom_range(4000, 32767));
        if ($urandom_range(1)) t.ax = -t.ax;
        t.ay = sym(20000);
        t.az = sym(20000);
      end
      default: begin
        t.has_sample = 1'($urandom_range(1));
        t.ax = SMP_W'($urandom);
        t.ay = SMP_W'($urandom);
        t.az = SMP_W'($urandom);
        t.stamp_ms = $urandom;
        wall_ms = t.stamp_ms;
      end
    endcase
    send_tick(t, 1'b0, '0);
  endtask

  // result side: ready pattern, with a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each result transfer with the oldest outstanding outcome
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got mag %0d flags %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (m_axis_tdata !== exp_o.mag) begin
          $display("%0t: magnitude_sq expected %0d got %0d", $time, exp_o.mag,
                   m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== exp_o.flags.fall_detected) begin
          $display("%0t: fall_detected expected %b got %b", $time,
                   exp_o.flags.fall_detected, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== exp_o.flags.alert_raised) begin
          $display("%0t: alert_raised expected %b got %b", $time,
                   exp_o.flags.alert_raised, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tuser[2] !== exp_o.flags.free_fall_active) begin
          $display("%0t: free_fall_active expected %b got %b", $time,
                   exp_o.flags.free_fall_active, m_axis_tuser[2]);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [LIMIT_W-1:0] ff_v;
    logic [LIMIT_W-1:0] imp_v;
    logic [CFG_W-1:0]   win_v;
    logic [CFG_W-1:0]   tout_v;
    logic [COOL_W-1:0]  cool_v;
    int                 phase_end;
    bit                 paused;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;

    ff_limit      = DEF_FREEFALL_LIMIT;
    impact_limit  = DEF_IMPACT_LIMIT;
    impact_window = DEF_IMPACT_WINDOW;
    ff_timeout    = DEF_FREEFALL_TIMEOUT;
    cooldown      = DEF_ALERT_COOLDOWN;
    armed         = 1'b0;
    window_start  = '0;
    held_mag      = ONE_G_SQ;
    last_alert    = '0;
    paused        = 1'b0;

    // reset defaults: held 1 g, extremes, fall with no alert, wrap
    directed_rows.push_back(tk_exp(0, 0, 0, 0, 0, ONE_G_SQ, 0, 0, 0));
    directed_rows.push_back(tk_exp(1, -32768, -32768, -32768, 10, MAX_MAG_SQ, 0, 0, 0));
    directed_rows.push_back(tk_exp(1, 32767, 32767, 32767, 20, 32'd3221028867, 0, 0, 0));
    directed_rows.push_back(tk_exp(1, 0, 0, 0, 100, 0, 0, 0, 1));
    directed_rows.push_back(tk(0, 0, 0, 0, 200));
    directed_rows.push_back(tk_exp(1, -32768, 0, 0, 300, 32'd1073741824, 1, 0, 0));
    directed_rows.push_back(tk(1, 100, -100, 50, 1000));
    directed_rows.push_back(tk(0, 0, 0, 0, 2001));
    directed_rows.push_back(tk(0, 0, 0, 0, 2002));
    directed_rows.push_back(tk(1, 0, 0, -32768, 2502));
    directed_rows.push_back(tk(1, 0, 0, 0, 70000));
    directed_rows.push_back(tk(1, 0, 32767, 0, 70499));
    directed_rows.push_back(tk(1, -1, 1, -1, 32'hFFFF_FF00));
    directed_rows.push_back(tk(1, 0, -32768, 32767, 32'h0000_0010));
    directed_rows.push_back(tk(1, 1000, 2000, -2000, 32'h0000_0020));
    // arm and impact in one tick, impact with timeout, wide and unknown writes
    directed_rows.push_back(wr(REG_IMPACT_LIMIT, 0));
    directed_rows.push_back(wr(REG_FREEFALL_LIMIT, MAX_MAG_SQ));
    directed_rows.push_back(wr(REG_ALERT_COOLDOWN, 0));
    directed_rows.push_back(wr(REG_IMPACT_WINDOW, 32'hABCD_FFFF));
    directed_rows.push_back(wr(REG_FREEFALL_TIMEOUT, 32'h1234_0000));
    directed_rows.push_back(wr(REG_SPARE_LO, 0));
    directed_rows.push_back(wr(REG_SPARE_HI, 32'hFFFF_FFFF));
    directed_rows.push_back(tk(1, 2, 0, 0, 5000));
    directed_rows.push_back(tk(1, 0, 0, 0, 5000));
    directed_rows.push_back(tk(1, 3, 0, 0, 5010));
    directed_rows.push_back(tk(1, 3, 0, 0, 5010));
    directed_rows.push_back(wr(REG_FREEFALL_LIMIT, 0));
    directed_rows.push_back(tk(1, 0, 0, 0, 6000));
    directed_rows.push_back(wr(REG_IMPACT_LIMIT, MAX_MAG_SQ));
    directed_rows.push_back(wr(REG_FREEFALL_LIMIT, 1));
    directed_rows.push_back(wr(REG_IMPACT_WINDOW, 0));
    directed_rows.push_back(wr(REG_ALERT_COOLDOWN, 32'hFFFF_FFFF));
    directed_rows.push_back(tk(1, 0, 0, 0, 7000));
    directed_rows.push_back(tk(1, -32768, -32768, -32768, 7000));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_outcomes_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with its own register setting; idle patterns are shared by pairs of phases
    wall_ms = 32'd100000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_outcomes_drained();
      win_v  = {16'($urandom), 16'($urandom_range(0, 65535))};
      tout_v = {16'($urandom), 16'($urandom_range(0, 65535))};
      case (p)
        0: begin
          ff_v   = DEF_FREEFALL_LIMIT;
          imp_v  = DEF_IMPACT_LIMIT;
          win_v  = {16'($urandom), DEF_IMPACT_WINDOW};
          tout_v = {16'($urandom), DEF_FREEFALL_TIMEOUT};
          cool_v = DEF_ALERT_COOLDOWN;
        end
        1: begin
          ff_v   = 32'd4000000;
          imp_v  = 32'd20000000;
          win_v  = {16'($urandom), 16'hFFFF};
          tout_v = {16'($urandom), 16'hFFFF};
          cool_v = '0;
        end
        2: begin
          ff_v   = MAX_MAG_SQ;
          imp_v  = '0;
          cool_v = 32'hFFFF_FFFF;
        end
        4: begin
          ff_v   = DEF_FREEFALL_LIMIT;
          imp_v  = DEF_IMPACT_LIMIT;
          win_v  = 32'd300;
          tout_v = 32'd400;
          cool_v = 32'd100;
        end
        default: begin
          ff_v   = $urandom_range(0, MAX_MAG_SQ);
          imp_v  = $urandom_range(0, MAX_MAG_SQ);
          cool_v = (p == 3) ? $urandom_range(0, 2000) : $urandom;
        end
      endcase
      write_reg(REG_FREEFALL_LIMIT, ff_v);
      write_reg(REG_IMPACT_LIMIT, imp_v);
      write_reg(REG_IMPACT_WINDOW, win_v);
      write_reg(REG_FREEFALL_TIMEOUT, tout_v);
      write_reg(REG_ALERT_COOLDOWN, cool_v);

      tx_idle_pct = (p < 2) ? 18 : (p < 4) ? 46 : 0;
      rx_idle_pct = (p < 2) ? 46 : (p < 4) ? 18 : 0;
      // long result hold-off while ticks keep coming
      if (p == 4) stall_request = 1'b1;
      phase_end = ticks_sent + ITEMS_PER_PHASE;

      while (ticks_sent < phase_end) begin
        // sender pause until the block has emptied
        if (p == 1 && !paused && ticks_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
          wait_outcomes_drained();
          paused = 1'b1;
        end
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 4)) random_step(MOTION_NOISE);
        end else begin
          repeat ($urandom_range(0, 3)) random_step(MOTION_REST);
          repeat ($urandom_range(1, 6)) random_step(MOTION_DROP);
          if ($urandom_range(3) != 0) random_step(MOTION_HIT);
        end
      end
    end

    // let the last results out, then watch for strays
    wait_outcomes_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_accel_fall_detector: PASS");
    end else begin
      $display("tb_accel_fall_detector: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/afd_pkg.sv
design/afd_magnitude.sv
design/accel_fall_detector.sv
tb/tb_accel_fall_detector.sv
